// ===== rtl/core/dhoa_pkg.sv =====
// dhoa_pkg: shared constants, types and codes for the double hash table
// no dependencies
`default_nettype none
package dhoa_pkg;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned SizeW = IdxW + 1;
  localparam int unsigned KeyW = 31;
  localparam int unsigned DataW = 32;
  localparam int unsigned ResetSize = 1021;

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdSearch = 2'd1,
    CmdRemove = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StMissing = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SlotEmpty   = 2'd0,
    SlotUsed    = 2'd1,
    SlotDeleted = 2'd2
  } slot_e;

  typedef enum logic [3:0] {
    SIdle, SClear, SMod, SModWait, SRead, SWait, SCheck, SStep, SDone
  } state_e;

  typedef struct packed {
    logic             start;
    logic [KeyW-1:0]  dividend;
    logic [SizeW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SizeW-1:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/double_hash_open_address_table.sv =====
// a request runs two remainder passes (key mod size for the start slot, key mod size-1
// for the stride), then read, wait and check per probe, with a step between probes;
// a refused insert, a walk of an empty table or an unused command answers next cycle
// a new request is accepted only in idle, after the result of the last one is taken
// on reset a clearing pass marks every slot empty before the first request
// table_size resets to 1021, entry count to zero
`default_nettype none
module double_hash_open_address_table (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [dhoa_pkg::SizeW-1:0]   cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   command_i,
  input  wire logic [dhoa_pkg::KeyW-1:0]    key_in_i,
  input  wire logic [dhoa_pkg::DataW-1:0]   data_in_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [1:0]                        status_o,
  output logic [dhoa_pkg::DataW-1:0]        data_out_o
);
  localparam int unsigned IW = dhoa_pkg::IdxW;
  localparam int unsigned SW = dhoa_pkg::SizeW;
  localparam int unsigned KW = dhoa_pkg::KeyW;
  localparam int unsigned DW = dhoa_pkg::DataW;

  dhoa_pkg::state_e state_q, state_d;
  logic [SW-1:0]    size_q, eff, count_q, count_d;
  logic [IW:0]      clr_q, clr_d;
  logic [1:0]       cmd_q;
  logic [KW-1:0]    key_q;
  logic [DW-1:0]    data_q;
  logic [SW-1:0]    pos_q, pos_d, stride_q, stride_d, first_q, first_d, n_q, n_d, sz_q;
  logic             phase_q, phase_d;
  logic [1:0]       st_q, st_d;
  logic [DW-1:0]    dout_q, dout_d;
  logic             ov_q, ov_d;
  logic [SW:0]      nxt;

  logic [1:0]    mstat [dhoa_pkg::TableDepth];
  logic [KW-1:0] mkey  [dhoa_pkg::TableDepth];
  logic [DW-1:0] mdata [dhoa_pkg::TableDepth];
  logic [1:0]    rstat;
  logic [KW-1:0] rkey;
  logic [DW-1:0] rdata;
  logic          we_s, we_kd;
  logic [IW-1:0] waddr;
  logic [1:0]    wstat;

  dhoa_pkg::div_req_t dreq;
  dhoa_pkg::div_rsp_t drsp;

  dhoa_rem u_rem (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    if (size_q < SW'(2)) eff = SW'(2);
    else if (size_q > SW'(dhoa_pkg::TableDepth)) eff = SW'(dhoa_pkg::TableDepth);
    else eff = size_q;
  end

  wire accept = in_valid_i && in_ready_o;
  assign nxt = {1'b0, pos_q} + {1'b0, stride_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dhoa_pkg::SClear: if (clr_q == (IW+1)'(dhoa_pkg::TableDepth - 1)) state_d = dhoa_pkg::SIdle;
      dhoa_pkg::SIdle: if (accept) begin
        if (command_i == dhoa_pkg::CmdInsert) begin
          state_d = (count_q < eff) ? dhoa_pkg::SMod : dhoa_pkg::SDone;
        end else if (command_i == dhoa_pkg::CmdSearch || command_i == dhoa_pkg::CmdRemove) begin
          state_d = (count_q != '0) ? dhoa_pkg::SMod : dhoa_pkg::SDone;
        end else state_d = dhoa_pkg::SDone;
      end
      dhoa_pkg::SMod: state_d = dhoa_pkg::SModWait;
      dhoa_pkg::SModWait: if (drsp.done) state_d = phase_q ? dhoa_pkg::SRead : dhoa_pkg::SMod;
      dhoa_pkg::SRead: state_d = dhoa_pkg::SWait;
      dhoa_pkg::SWait: state_d = dhoa_pkg::SCheck;
      dhoa_pkg::SCheck: begin
        if (cmd_q == dhoa_pkg::CmdInsert) begin
          state_d = (rstat != dhoa_pkg::SlotUsed) ? dhoa_pkg::SDone : dhoa_pkg::SStep;
        end else if (rstat == dhoa_pkg::SlotEmpty ||
                     (rstat == dhoa_pkg::SlotUsed && rkey == key_q)) begin
          state_d = dhoa_pkg::SDone;
        end else state_d = dhoa_pkg::SStep;
      end
      dhoa_pkg::SStep: begin
        if (n_q + 1'b1 >= sz_q) state_d = dhoa_pkg::SDone;
        else if (cmd_q != dhoa_pkg::CmdInsert &&
                 ((nxt >= {1'b0, sz_q}) ? SW'(nxt - {1'b0, sz_q}) : SW'(nxt)) == first_q)
          state_d = dhoa_pkg::SDone;
        else state_d = dhoa_pkg::SRead;
      end
      dhoa_pkg::SDone: if (ov_q && out_ready_i) state_d = dhoa_pkg::SIdle;
      default: state_d = dhoa_pkg::SIdle;
    endcase
  end

  always_comb begin
    clr_d = clr_q;
    count_d = count_q;
    pos_d = pos_q;
    stride_d = stride_q;
    first_d = first_q;
    n_d = n_q;
    phase_d = phase_q;
    st_d = st_q;
    dout_d = dout_q;
    ov_d = ov_q;
    dreq = '0;
    we_s = 1'b0;
    we_kd = 1'b0;
    waddr = pos_q[IW-1:0];
    wstat = dhoa_pkg::SlotUsed;
    in_ready_o = (state_q == dhoa_pkg::SIdle);
    unique case (state_q)
      dhoa_pkg::SClear: begin
        we_s = 1'b1;
        waddr = clr_q[IW-1:0];
        wstat = dhoa_pkg::SlotEmpty;
        clr_d = clr_q + 1'b1;
      end
      dhoa_pkg::SIdle: begin
        phase_d = 1'b0;
        n_d = '0;
        dout_d = '0;
        st_d = (command_i == dhoa_pkg::CmdInsert) ? dhoa_pkg::StFull : dhoa_pkg::StMissing;
        if (accept && state_d == dhoa_pkg::SDone) ov_d = 1'b1;
      end
      dhoa_pkg::SMod: begin
        dreq.start = 1'b1;
        dreq.dividend = key_q;
        dreq.divisor = phase_q ? SW'(sz_q - 1'b1) : sz_q;
      end
      dhoa_pkg::SModWait: if (drsp.done) begin
        if (!phase_q) begin
          pos_d = drsp.rem;
          first_d = drsp.rem;
        end else stride_d = SW'(drsp.rem + 1'b1);
        phase_d = 1'b1;
      end
      dhoa_pkg::SCheck: begin
        if (cmd_q == dhoa_pkg::CmdInsert) begin
          if (rstat != dhoa_pkg::SlotUsed) begin
            we_s = 1'b1;
            we_kd = 1'b1;
            count_d = count_q + 1'b1;
            st_d = dhoa_pkg::StOk;
            ov_d = 1'b1;
          end
        end else if (rstat == dhoa_pkg::SlotEmpty) begin
          ov_d = 1'b1;
        end else if (rstat == dhoa_pkg::SlotUsed && rkey == key_q) begin
          st_d = dhoa_pkg::StOk;
          ov_d = 1'b1;
          if (cmd_q == dhoa_pkg::CmdRemove) begin
            we_s = 1'b1;
            wstat = dhoa_pkg::SlotDeleted;
            dout_d = rdata;
            count_d = count_q - 1'b1;
          end
        end
      end
      dhoa_pkg::SStep: begin
        pos_d = (nxt >= {1'b0, sz_q}) ? SW'(nxt - {1'b0, sz_q}) : SW'(nxt);
        n_d = n_q + 1'b1;
        if (state_d == dhoa_pkg::SDone) ov_d = 1'b1;
      end
      dhoa_pkg::SDone: if (out_ready_i) ov_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dhoa_pkg::SClear;
      size_q <= SW'(dhoa_pkg::ResetSize);
      count_q <= '0;
      clr_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
      count_q <= count_d;
      clr_q <= clr_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      key_q <= key_in_i;
      data_q <= data_in_i;
      sz_q <= eff;
    end
    pos_q <= pos_d;
    stride_q <= stride_d;
    first_q <= first_d;
    n_q <= n_d;
    phase_q <= phase_d;
    st_q <= st_d;
    dout_q <= dout_d;
  end

  always_ff @(posedge clk_i) begin
    if (we_s) mstat[waddr] <= wstat;
    if (we_kd) begin
      mkey[waddr] <= key_q;
      mdata[waddr] <= data_q;
    end
    rstat <= mstat[pos_q[IW-1:0]];
    rkey <= mkey[pos_q[IW-1:0]];
    rdata <= mdata[pos_q[IW-1:0]];
  end

  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign data_out_o = dout_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o)
    else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= SW'(dhoa_pkg::TableDepth))
    else $error("entry count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && status_o != dhoa_pkg::StOk) |-> data_out_o == '0)
    else $error("data on failed request");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == dhoa_pkg::SStep) |-> pos_q < sz_q)
    else $error("probe out of range");
endmodule
`default_nettype wire

// ===== rtl/core/dhoa_rem.sv =====
// dhoa_rem: restoring bit-serial remainder unit, one key bit per cycle
// depends on dhoa_pkg
`default_nettype none
module dhoa_rem (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dhoa_pkg::div_req_t req_i,
  output dhoa_pkg::div_rsp_t      rsp_o
);
  localparam int unsigned CntW = $clog2(dhoa_pkg::KeyW + 1);

  logic [dhoa_pkg::KeyW-1:0]  num_q, num_d;
  logic [dhoa_pkg::SizeW:0]   rem_q, rem_d;
  logic [dhoa_pkg::SizeW-1:0] div_q, div_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d, done_q, done_d;
  logic [dhoa_pkg::SizeW+1:0] trial;
  logic [dhoa_pkg::SizeW+1:0] shifted;

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    div_d = div_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q, num_q[dhoa_pkg::KeyW-1]};
    trial = shifted - {2'b00, div_q};
    if (req_i.start) begin
      num_d = req_i.dividend;
      div_d = req_i.divisor;
      rem_d = '0;
      cnt_d = CntW'(dhoa_pkg::KeyW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = trial[dhoa_pkg::SizeW+1] ? shifted[dhoa_pkg::SizeW:0] : trial[dhoa_pkg::SizeW:0];
      num_d = {num_q[dhoa_pkg::KeyW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem = rem_q[dhoa_pkg::SizeW-1:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("remainder done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> (rem_q < {1'b0, div_q}))
    else $error("remainder not reduced");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> cnt_q != '0)
    else $error("busy with zero count");
endmodule
`default_nettype wire

// ===== tb/double_hash_open_address_table_test.sv =====
// testbench for double_hash_open_address_table: random and directed requests
// checked against a predicting scoreboard; depends on dhoa_pkg and the block
`timescale 1ns / 1ps

class table_scoreboard;
  int unsigned size_reg;
  dhoa_pkg::slot_e slot_state[dhoa_pkg::TableDepth];
  logic [30:0] slot_key[dhoa_pkg::TableDepth];
  logic [31:0] slot_data[dhoa_pkg::TableDepth];
  int unsigned used_count;
  dhoa_pkg::status_e status_q[$];
  logic [31:0] data_q[$];
  int errors;

  function new();
    size_reg = dhoa_pkg::ResetSize;
    foreach (slot_state[i]) slot_state[i] = dhoa_pkg::SlotEmpty;
    used_count = 0;
    errors = 0;
  endfunction

  function void set_size(logic [10:0] v);
    size_reg = v;
  endfunction

  function int unsigned active_size();
    if (size_reg < 2) return 2;
    if (size_reg > dhoa_pkg::TableDepth) return dhoa_pkg::TableDepth;
    return size_reg;
  endfunction

  function int pending();
    return status_q.size();
  endfunction

  function void note_request(dhoa_pkg::cmd_e cmd, logic [30:0] key, logic [31:0] din);
    int unsigned sz, pos, stride, first;
    int hit;
    dhoa_pkg::status_e st;
    logic [31:0] dout;
    sz = active_size();
    pos = key % sz;
    stride = 1 + key % (sz - 1);
    first = pos;
    st = dhoa_pkg::StMissing;
    dout = '0;
    hit = -1;
    if (cmd == dhoa_pkg::CmdInsert) begin
      st = dhoa_pkg::StFull;
      if (used_count < sz) begin
        for (int n = 0; n < sz; n++) begin
          if (slot_state[pos] != dhoa_pkg::SlotUsed) begin
            slot_state[pos] = dhoa_pkg::SlotUsed;
            slot_key[pos] = key;
            slot_data[pos] = din;
            used_count++;
            st = dhoa_pkg::StOk;
            break;
          end
          pos = (pos + stride) % sz;
        end
      end
    end else if (cmd != dhoa_pkg::CmdNone && used_count != 0) begin
      for (int n = 0; n < sz; n++) begin
        if (slot_state[pos] == dhoa_pkg::SlotEmpty) break;
        if (slot_state[pos] == dhoa_pkg::SlotUsed && slot_key[pos] == key) begin
          hit = pos;
          break;
        end
        pos = (pos + stride) % sz;
        if (pos == first) break;
      end
      if (hit >= 0) begin
        st = dhoa_pkg::StOk;
        if (cmd == dhoa_pkg::CmdRemove) begin
          dout = slot_data[hit];
          slot_state[hit] = dhoa_pkg::SlotDeleted;
          used_count--;
        end
      end
    end
    status_q.push_back(st);
    data_q.push_back(dout);
  endfunction

  function void check_result(logic [1:0] st, logic [31:0] dout);
    dhoa_pkg::status_e exp_st;
    logic [31:0] exp_data;
    if (status_q.size() == 0) begin
      $display("%0t: unexpected result status %0d data %h", $time, st, dout);
      errors++;
      return;
    end
    exp_st = status_q.pop_front();
    exp_data = data_q.pop_front();
    if (st !== exp_st) begin
      $display("%0t: status expected %0d actual %0d", $time, exp_st, st);
      errors++;
    end
    if (dout !== exp_data) begin
      $display("%0t: data_out expected %h actual %h", $time, exp_data, dout);
      errors++;
    end
  endfunction
endclass

module double_hash_open_address_table_test;
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [10:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  command_i;
  logic [30:0] key_in_i;
  logic [31:0] data_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [31:0] data_out_o;

  table_scoreboard sb;
  int burst_left;
  int stall_mode;
  int stall_cnt;
  logic [10:0] sizes[12];

  double_hash_open_address_table u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .key_in_i    (key_in_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("*** FAILED ***");
    $finish;
  end

  // the receiver checks each taken result and redraws its stall pattern from a stall counter
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(status_o, data_out_o);
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      2: out_ready_i <= (stall_cnt % 3 == 0);
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_request(dhoa_pkg::cmd_e cmd, logic [30:0] key, logic [31:0] din);
    int gap;
    command_i <= cmd;
    key_in_i <= key;
    data_in_i <= din;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(cmd, key, din);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_size(logic [10:0] v);
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_size(v);
  endtask

  task automatic random_phase(int count);
    int unsigned span;
    int r;
    dhoa_pkg::cmd_e cmd;
    logic [30:0] key;
    span = 3 * sb.active_size();
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) cmd = dhoa_pkg::CmdInsert;
      else if (r < 65) cmd = dhoa_pkg::CmdSearch;
      else if (r < 95) cmd = dhoa_pkg::CmdRemove;
      else cmd = dhoa_pkg::CmdNone;
      if ($urandom_range(0, 3) == 0) key = 31'($urandom);
      else key = 31'($urandom_range(0, span));
      send_request(cmd, key, $urandom);
    end
  endtask

  initial begin
    sizes = '{11'd3, 11'd7, 11'd13, 11'd2047, 11'd1, 11'd5,
              11'd11, 11'd1024, 11'd2, 11'd17, 11'd0, 11'd31};
    sb = new();
    burst_left = 0;
    stall_mode = 0;
    stall_cnt = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    command_i = dhoa_pkg::CmdInsert;
    key_in_i = '0;
    data_in_i = '0;
    out_ready_i = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset size
    send_request(dhoa_pkg::CmdSearch, 31'd5, 32'h0);
    send_request(dhoa_pkg::CmdRemove, 31'd5, 32'h0);
    send_request(dhoa_pkg::CmdNone, 31'h7fffffff, 32'hffffffff);
    send_request(dhoa_pkg::CmdInsert, 31'd0, 32'h80000000);
    send_request(dhoa_pkg::CmdInsert, 31'h7fffffff, 32'h7fffffff);
    send_request(dhoa_pkg::CmdInsert, 31'd1021, 32'h12345678);
    send_request(dhoa_pkg::CmdSearch, 31'd1021, 32'h0);
    send_request(dhoa_pkg::CmdSearch, 31'd2042, 32'h0);
    send_request(dhoa_pkg::CmdRemove, 31'd0, 32'h0);
    send_request(dhoa_pkg::CmdSearch, 31'd1021, 32'h0);
    send_request(dhoa_pkg::CmdInsert, 31'd5, 32'hffffffff);
    send_request(dhoa_pkg::CmdInsert, 31'd5, 32'h00000001);
    send_request(dhoa_pkg::CmdRemove, 31'd5, 32'h0);
    send_request(dhoa_pkg::CmdRemove, 31'd5, 32'h0);
    send_request(dhoa_pkg::CmdRemove, 31'd5, 32'h0);
    send_request(dhoa_pkg::CmdRemove, 31'h7fffffff, 32'h0);
    // tiny table: fill until refused, then walk back through deleted slots
    write_size(11'd2);
    send_request(dhoa_pkg::CmdInsert, 31'd4, 32'haaaa5555);
    send_request(dhoa_pkg::CmdInsert, 31'd6, 32'h5555aaaa);
    send_request(dhoa_pkg::CmdInsert, 31'd8, 32'h1);
    send_request(dhoa_pkg::CmdSearch, 31'd9, 32'h0);
    send_request(dhoa_pkg::CmdRemove, 31'd4, 32'h0);
    send_request(dhoa_pkg::CmdSearch, 31'd6, 32'h0);
    send_request(dhoa_pkg::CmdInsert, 31'd8, 32'h2);
    write_size(11'd0);
    send_request(dhoa_pkg::CmdInsert, 31'd1, 32'h3);
    send_request(dhoa_pkg::CmdSearch, 31'd8, 32'h0);

    foreach (sizes[i]) begin
      write_size(sizes[i]);
      random_phase((sizes[i] >= 1000) ? 40 : 70);
    end

    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
